[sv/owa_pkg.sv]
`default_nettype none
// ============================================================================
// owa_pkg: shared types and constants of the oxygen window averager
// Holds the field widths, the calibration constants and the register indexes
// of the configuration port.
// ============================================================================
package owa_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned ReadingW = 15;  // 255*100 + 255*10 + 255 = 28305
  localparam int unsigned KeyW     = 15;  // largest key is 16712
  localparam int unsigned ScaledW  = 29;
  localparam int unsigned SumW     = 36;
  localparam int unsigned CfgIdxW  = 2;

  // Default key: round(20.9 / 120 * 65536).
  localparam logic [KeyW-1:0] DefaultKey = 15'd11414;

  // key = (code*65536 + 500) / 1000. The numerator stays below 2^24, where
  // multiplying by ceil(2^34 / 1000) and dropping 34 bits gives the exact
  // quotient.
  localparam int unsigned KeyNumW   = 24;
  localparam int unsigned RecipW    = 25;
  localparam int unsigned KeyShift  = 34;
  localparam logic [RecipW-1:0]  KeyRecip = 25'd17179870;
  localparam logic [KeyNumW-1:0] KeyRound = 24'd500;

  localparam logic [ReadingW-1:0] WeightWhole  = 15'd100;
  localparam logic [ReadingW-1:0] WeightTenths = 15'd10;

  localparam logic [CfgIdxW-1:0] CfgKeyCode   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgWindowLen = 2'd1;

  localparam logic [ByteW-1:0] ResetWindowLen = 8'd10;

endpackage
`default_nettype wire

[sv/oxygen_window_averager_core.sv]
`default_nettype none
// ============================================================================
// oxygen_window_averager_core: sliding-window mean of calibrated O2 readings
// Scales each raw sensor reading by a Q16 key, keeps the newest readings in a
// ring memory and returns the truncated mean of the filled window.
// ============================================================================
// One item is handled at a time. An item passes through these states in
// order: S_OLD reads the oldest entry, S_SUB takes it out of the running sum
// (skipped while filling), S_ADD adds the new reading and writes the ring,
// S_DIV waits for the bit-serial divider that forms the mean, and S_OUT hands
// the quotient to the output register. When window_len is zero the result
// (mean 0, disabled flag set) goes from acceptance straight to S_OUT and
// nothing is stored. When window_len has been lowered below the current fill
// count, the next item first rebuilds the running sum from the newest
// remaining entries, reading each in S_RRD and adding it in S_RACC. The
// result sits in an output register; a new item is taken once the block has
// moved its last result there, even if that result has not been taken yet.
// Configuration writes are always accepted; a window_len above MAX_WINDOW
// acts as MAX_WINDOW. The ring needs no clearing after reset, since only
// entries written since reset are ever read.
module oxygen_window_averager_core #(
  parameter int unsigned MAX_WINDOW = 128
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Configuration write port.
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [owa_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [owa_pkg::ByteW-1:0]      cfg_data_i,
  // Input items.
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [owa_pkg::ByteW-1:0]      whole_part_i,
  input  wire logic [owa_pkg::ByteW-1:0]      tenths_part_i,
  input  wire logic [owa_pkg::ByteW-1:0]      hundredths_part_i,
  // Result items.
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic      [owa_pkg::ScaledW-1:0]    mean_level_o,
  output logic                                window_disabled_o
);

  localparam int unsigned SlotW = $clog2(MAX_WINDOW);
  localparam int unsigned CntW  = $clog2(MAX_WINDOW + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RRD,
    S_RACC,
    S_OLD,
    S_SUB,
    S_ADD,
    S_DIV,
    S_OUT
  } state_e;

  state_e state_q;

  logic [owa_pkg::ByteW-1:0]   key_code_q;
  logic [owa_pkg::ByteW-1:0]   window_len_q;
  logic [CntW-1:0]             len_q;
  logic [CntW-1:0]             fill_q;
  logic [CntW-1:0]             k_q;
  logic [SlotW-1:0]            slot_q;
  logic [owa_pkg::SumW-1:0]    sum_q;
  logic                        disabled_q;

  logic                        in_fire;
  logic [8:0]                  len_wide;
  logic [CntW-1:0]             len_now;
  logic [owa_pkg::ScaledW-1:0] scaled;
  logic [owa_pkg::ScaledW-1:0] rdata;
  logic                        mem_re;
  logic [SlotW-1:0]            mem_raddr;
  logic                        mem_we;
  logic [owa_pkg::SumW-1:0]    sum_added;
  logic                        div_start;
  logic                        div_done;
  logic [owa_pkg::SumW-1:0]    quotient;

  // Slot that lies k places behind the write slot, modulo MAX_WINDOW.
  function automatic logic [SlotW-1:0] slot_back(input logic [SlotW-1:0] slot,
                                                 input logic [CntW-1:0]  k);
    logic [CntW:0] diff;
    diff = (CntW+1)'(slot) + (CntW+1)'(MAX_WINDOW) - (CntW+1)'(k);
    if (diff >= (CntW+1)'(MAX_WINDOW)) begin
      diff = diff - (CntW+1)'(MAX_WINDOW);
    end
    return diff[SlotW-1:0];
  endfunction

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;

  // Effective window length, capped at the ring depth.
  assign len_wide = ({1'b0, window_len_q} > 9'(MAX_WINDOW)) ? 9'(MAX_WINDOW)
                                                            : {1'b0, window_len_q};
  assign len_now  = len_wide[CntW-1:0];

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_code_q   <= '0;
      window_len_q <= owa_pkg::ResetWindowLen;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        owa_pkg::CfgKeyCode:   key_code_q   <= cfg_data_i;
        owa_pkg::CfgWindowLen: window_len_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  owa_scaler u_scaler (
    .clk_i        (clk_i),
    .load_i       (in_fire),
    .whole_i      (whole_part_i),
    .tenths_i     (tenths_part_i),
    .hundredths_i (hundredths_part_i),
    .key_code_i   (key_code_q),
    .scaled_o     (scaled)
  );

  // Memory access. A rebuild reads the entries one by one; a full window reads
  // the oldest entry so that it can leave the sum.
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = slot_back(slot_q, len_q);
    if (state_q == S_RRD) begin
      mem_re    = 1'b1;
      mem_raddr = slot_back(slot_q, k_q);
    end else if (state_q == S_OLD && fill_q == len_q) begin
      mem_re = 1'b1;
    end
  end

  assign mem_we    = (state_q == S_ADD);
  assign sum_added = sum_q + owa_pkg::SumW'(scaled);
  assign div_start = (state_q == S_ADD);

  owa_ring_mem #(
    .Depth (MAX_WINDOW),
    .AddrW (SlotW),
    .DataW (owa_pkg::ScaledW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (slot_q),
    .wdata_i (scaled),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (rdata)
  );

  owa_divider #(
    .DivW (CntW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_added),
    .divisor_i  (fill_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Sequencer with window state and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      fill_q      <= '0;
      k_q         <= '0;
      slot_q      <= '0;
      sum_q       <= '0;
      disabled_q  <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      // In S_OUT the output register is refilled, so it is never cleared there.
      if (out_valid_o && out_ready_i && state_q != S_OUT) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            len_q      <= len_now;
            disabled_q <= (len_now == '0);
            if (len_now == '0) begin
              state_q <= S_OUT;
            end else if (fill_q > len_now) begin
              // Window was shortened: clamp and rebuild the sum.
              fill_q  <= len_now;
              sum_q   <= '0;
              k_q     <= CntW'(1);
              state_q <= S_RRD;
            end else begin
              state_q <= S_OLD;
            end
          end
        end
        S_RRD: begin
          state_q <= S_RACC;
        end
        S_RACC: begin
          sum_q <= sum_q + owa_pkg::SumW'(rdata);
          if (k_q == fill_q) begin
            state_q <= S_OLD;
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= S_RRD;
          end
        end
        S_OLD: begin
          if (fill_q == len_q) begin
            state_q <= S_SUB;
          end else begin
            fill_q  <= fill_q + 1'b1;
            state_q <= S_ADD;
          end
        end
        S_SUB: begin
          sum_q   <= sum_q - owa_pkg::SumW'(rdata);
          state_q <= S_ADD;
        end
        S_ADD: begin
          sum_q   <= sum_added;
          slot_q  <= (slot_q == SlotW'(MAX_WINDOW - 1)) ? '0 : slot_q + 1'b1;
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_o || out_ready_i) begin
            out_valid_o <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && (!out_valid_o || out_ready_i)) begin
      window_disabled_o <= disabled_q;
      mean_level_o      <= disabled_q ? '0 : quotient[owa_pkg::ScaledW-1:0];
    end
  end

endmodule
`default_nettype wire

[sv/owa_ring_mem.sv]
`default_nettype none
// ============================================================================
// owa_ring_mem: sample ring storage
// Simple dual-port synchronous memory, one write and one read per cycle,
// read data registered.
// ============================================================================
module owa_ring_mem #(
  parameter int unsigned Depth = 128,
  parameter int unsigned AddrW = 7,
  parameter int unsigned DataW = 29
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [DataW-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

[sv/owa_scaler.sv]
`default_nettype none
// ============================================================================
// owa_scaler: calibration of one raw reading
// First stage forms the reading in hundredths and the key numerator product;
// second stage multiplies the reading by the Q16 key.
// ============================================================================
module owa_scaler (
  input  wire logic                         clk_i,
  input  wire logic                         load_i,
  input  wire logic [owa_pkg::ByteW-1:0]    whole_i,
  input  wire logic [owa_pkg::ByteW-1:0]    tenths_i,
  input  wire logic [owa_pkg::ByteW-1:0]    hundredths_i,
  input  wire logic [owa_pkg::ByteW-1:0]    key_code_i,
  output logic      [owa_pkg::ScaledW-1:0]  scaled_o
);

  localparam int unsigned ProdW = owa_pkg::KeyNumW + owa_pkg::RecipW;

  logic [owa_pkg::ReadingW-1:0] reading_d, reading_q;
  logic [owa_pkg::KeyNumW-1:0]  key_num;
  logic [ProdW-1:0]             key_prod_q;
  logic                         key_dflt_q;
  logic [owa_pkg::KeyW-1:0]     key;
  logic [2*owa_pkg::ReadingW-1:0] scaled_full;

  assign reading_d = owa_pkg::ReadingW'(whole_i) * owa_pkg::WeightWhole
                   + owa_pkg::ReadingW'(tenths_i) * owa_pkg::WeightTenths
                   + owa_pkg::ReadingW'(hundredths_i);

  assign key_num = {key_code_i, 16'h0000} + owa_pkg::KeyRound;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      reading_q  <= reading_d;
      key_prod_q <= ProdW'(key_num) * ProdW'(owa_pkg::KeyRecip);
      key_dflt_q <= (key_code_i == '0);
    end
  end

  assign key = key_dflt_q ? owa_pkg::DefaultKey
                          : key_prod_q[owa_pkg::KeyShift +: owa_pkg::KeyW];

  assign scaled_full = reading_q * key;

  // Free running: the result is registered from the loaded stage and then holds.
  always_ff @(posedge clk_i) begin
    scaled_o <= scaled_full[owa_pkg::ScaledW-1:0];
  end

endmodule
`default_nettype wire

[sv/owa_divider.sv]
`default_nettype none
// ============================================================================
// owa_divider: radix-2 restoring divider
// Divides the running sum by the fill count, one quotient bit per cycle.
// ============================================================================
module owa_divider #(
  parameter int unsigned DivW = 8
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [owa_pkg::SumW-1:0]  dividend_i,
  input  wire logic [DivW-1:0]           divisor_i,
  output logic                           done_o,
  output logic      [owa_pkg::SumW-1:0]  quotient_o
);

  localparam int unsigned CntW = $clog2(owa_pkg::SumW + 1);

  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic [DivW-1:0] divisor_q;
  logic [DivW-1:0] rem_q;
  logic [DivW:0]   trial;
  logic            fits;

  assign trial = {rem_q, quotient_o[owa_pkg::SumW-1]};
  assign fits  = (trial >= {1'b0, divisor_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      // Done rises for one cycle after the last quotient bit is shifted in.
      done_o <= !start_i && busy_q && (cnt_q == CntW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(owa_pkg::SumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quotient_o <= dividend_i;
      divisor_q  <= divisor_i;
      rem_q      <= '0;
    end else if (busy_q) begin
      rem_q      <= fits ? DivW'(trial - {1'b0, divisor_q}) : trial[DivW-1:0];
      quotient_o <= {quotient_o[owa_pkg::SumW-2:0], fits};
    end
  end

endmodule
`default_nettype wire

[sv/owa_checker.sv]
`default_nettype none
// ============================================================================
// owa_checker: port-level checks of the oxygen window averager
// Watches the handshakes and result fields of the top level.
// ============================================================================
module owa_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_ready_i,
  input wire logic [owa_pkg::ScaledW-1:0]   mean_level_o,
  input wire logic                          window_disabled_o
);

  // A disabled window reports a zero mean.
  a_disabled_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && window_disabled_o) |-> (mean_level_o == '0))
    else $error("disabled result carries a nonzero mean");

  // The mean never exceeds the largest scaled reading.
  a_mean_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (mean_level_o <= 29'd473033160))
    else $error("mean above the largest scaled reading");

  // One item at a time: after an item is taken, input is closed.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted while an item is in work");

  // A waiting result holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(mean_level_o) && $stable(window_disabled_o)))
    else $error("result changed before it was taken");

endmodule

bind oxygen_window_averager_core owa_checker u_owa_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .mean_level_o      (mean_level_o),
  .window_disabled_o (window_disabled_o)
);
`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb_top: self-checking bench for oxygen_window_averager_core
// Sends raw oxygen sensor readings under a range of calibration and window
// settings, checks every mean and disabled flag against a local sliding-window
// predictor or a pinned table value, opens with a short table of directed
// readings, then runs random phases, most with random idling on both sides.
// ============================================================================
module tb_top;

  localparam int unsigned MaxWindow = 128;
  // round(20.9 / 120 * 65536), the key used when the calibration byte is zero.
  localparam int unsigned DefaultKeyQ16 = 11414;

  typedef enum logic {RowItem, RowReg} row_kind_e;

  // One row of the directed table. A register row carries its value in w.
  typedef struct packed {
    row_kind_e                    kind;
    logic [owa_pkg::CfgIdxW-1:0]  reg_idx;
    logic [owa_pkg::ByteW-1:0]    w;
    logic [owa_pkg::ByteW-1:0]    t;
    logic [owa_pkg::ByteW-1:0]    h;
    logic                         pinned;
    logic [owa_pkg::ScaledW-1:0]  mean;
    logic                         dis;
  } plan_row_t;

  typedef struct packed {
    logic [owa_pkg::ScaledW-1:0]  mean;
    logic                         dis;
  } mean_rec_t;

  // Clock, reset and the ports of the block.
  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [owa_pkg::CfgIdxW-1:0]   cfg_index_i = '0;
  logic [owa_pkg::ByteW-1:0]     cfg_data_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          in_ready_o;
  logic [owa_pkg::ByteW-1:0]     whole_part_i = '0;
  logic [owa_pkg::ByteW-1:0]     tenths_part_i = '0;
  logic [owa_pkg::ByteW-1:0]     hundredths_part_i = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic [owa_pkg::ScaledW-1:0]   mean_level_o;
  logic                          window_disabled_o;

  // A typed-in expectation travels with the item it belongs to.
  logic                          pin_on = 1'b0;
  logic [owa_pkg::ScaledW-1:0]   pin_mean = '0;
  logic                          pin_dis = 1'b0;

  // When set, neither side idles.
  bit steady = 1'b0;

  // Predictor state, starting at the reset values of the block.
  logic [owa_pkg::ByteW-1:0]     cal_code = '0;
  logic [owa_pkg::ByteW-1:0]     avg_len = 8'd10;
  logic [owa_pkg::ScaledW-1:0]   ring_mem [MaxWindow];
  logic [owa_pkg::SumW-1:0]      level_sum = '0;
  logic [7:0]                    used_cnt = '0;
  logic [6:0]                    next_slot = '0;

  mean_rec_t pending_means [$];
  plan_row_t plan_q [$];
  int unsigned err_cnt = 0;
  int unsigned means_checked = 0;
  int unsigned readings_sent = 0;
  int unsigned settings_seen = 0;

  oxygen_window_averager_core #(
    .MAX_WINDOW(MaxWindow)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .whole_part_i     (whole_part_i),
    .tenths_part_i    (tenths_part_i),
    .hundredths_part_i(hundredths_part_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .mean_level_o     (mean_level_o),
    .window_disabled_o(window_disabled_o)
  );

  always #1 clk_i = ~clk_i;

  // Runs one reading through the predictor and updates its window state.
  task automatic predict_mean(input logic [7:0] w, input logic [7:0] t,
                              input logic [7:0] h,
                              output logic [owa_pkg::ScaledW-1:0] mean,
                              output logic dis);
    int unsigned eff_len;
    int unsigned key;
    int unsigned reading;
    int unsigned k;
    logic [owa_pkg::ScaledW-1:0] scaled;
    mean = '0;
    dis = 1'b1;
    eff_len = avg_len;
    if (eff_len != 0) begin
      if (eff_len > MaxWindow) eff_len = MaxWindow;
      // A shortened window keeps only its newest entries, so the sum is
      // rebuilt from them.
      if (used_cnt > eff_len) begin
        used_cnt = 8'(eff_len);
        level_sum = '0;
        for (k = 1; k <= eff_len; k++) begin
          level_sum = level_sum + 36'(ring_mem[7'(next_slot - k)]);
        end
      end
      if (cal_code == '0) key = DefaultKeyQ16;
      else key = (int'(cal_code) * 65536 + 500) / 1000;
      reading = int'(w) * 100 + int'(t) * 10 + int'(h);
      scaled = 29'(reading * key);
      // On a full window the oldest entry leaves before the new one enters.
      if (used_cnt == eff_len) level_sum = level_sum - 36'(ring_mem[7'(next_slot - eff_len)]);
      else used_cnt = used_cnt + 8'd1;
      level_sum = level_sum + 36'(scaled);
      ring_mem[next_slot] = scaled;
      next_slot = next_slot + 7'd1;
      mean = 29'(level_sum / 36'(used_cnt));
      dis = 1'b0;
    end
  endtask

  // Accepted results are checked, register writes reach the predictor and
  // accepted readings queue their expected means, all on the same edge.
  always @(posedge clk_i) begin : scoreboard
    mean_rec_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_means.size() == 0) begin
          err_cnt++;
          $display("%0t: result with none expected: expected nothing, got mean %0d dis %0b",
                   $time, mean_level_o, window_disabled_o);
        end else begin
          want = pending_means.pop_front();
          means_checked++;
          if (mean_level_o !== want.mean) begin
            err_cnt++;
            $display("%0t: mean_level mismatch: expected %0d, got %0d",
                     $time, want.mean, mean_level_o);
          end
          if (window_disabled_o !== want.dis) begin
            err_cnt++;
            $display("%0t: window_disabled mismatch: expected %0b, got %0b",
                     $time, want.dis, window_disabled_o);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          owa_pkg::CfgKeyCode:   cal_code = cfg_data_i;
          owa_pkg::CfgWindowLen: avg_len = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        predict_mean(whole_part_i, tenths_part_i, hundredths_part_i, want.mean, want.dis);
        if (pin_on) begin
          want.mean = pin_mean;
          want.dis = pin_dis;
        end
        pending_means.push_back(want);
      end
    end
  end

  // Result side: ready goes low in segments, now and then for a long stall.
  initial begin : result_side
    int unsigned seg;
    bit stall;
    wait (rst_ni);
    forever begin
      seg = $urandom_range(1, 12);
      stall = !steady && ($urandom_range(0, 99) < 16);
      if (stall && $urandom_range(0, 15) == 0) seg = $urandom_range(20, 60);
      repeat (seg) begin
        out_ready_i <= !stall;
        @(posedge clk_i);
      end
    end
  end

  // Stops sending and waits until every expected result has been taken.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_means.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Writes one register. The block must be idle, so readings are drained
  // first; consecutive writes keep valid high.
  task automatic write_reg(input logic [owa_pkg::CfgIdxW-1:0] idx,
                           input logic [owa_pkg::ByteW-1:0] val);
    if (in_valid_i) settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic send_reading(input logic [7:0] w, input logic [7:0] t,
                              input logic [7:0] h, input logic pinned,
                              input logic [owa_pkg::ScaledW-1:0] mean,
                              input logic dis);
    cfg_valid_i <= 1'b0;
    if (!steady && $urandom_range(0, 99) < 19) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 45)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    whole_part_i <= w;
    tenths_part_i <= t;
    hundredths_part_i <= h;
    pin_on <= pinned;
    pin_mean <= mean;
    pin_dis <= dis;
    do @(posedge clk_i); while (!in_ready_o);
    readings_sent++;
  endtask

  task automatic row_item(input logic [7:0] w, input logic [7:0] t, input logic [7:0] h);
    plan_q.push_back('{RowItem, '0, w, t, h, 1'b0, '0, 1'b0});
  endtask

  task automatic row_pin(input logic [7:0] w, input logic [7:0] t, input logic [7:0] h,
                         input logic [owa_pkg::ScaledW-1:0] mean, input logic dis);
    plan_q.push_back('{RowItem, '0, w, t, h, 1'b1, mean, dis});
  endtask

  task automatic row_reg(input logic [owa_pkg::CfgIdxW-1:0] idx, input logic [7:0] val);
    plan_q.push_back('{RowReg, idx, val, 8'd0, 8'd0, 1'b0, '0, 1'b0});
  endtask

  // Random bytes lean on the extremes now and then.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    plan_row_t row;
    int ph;
    int n;
    int count;
    logic [7:0] key;
    logic [7:0] len;

    foreach (ring_mem[i]) ring_mem[i] = '0;

    // Reset values: default key, window of ten.
    row_pin(8'd0, 8'd0, 8'd0, 29'd0, 1'b0);
    row_pin(8'd1, 8'd0, 8'd0, 29'd570700, 1'b0);
    row_item(8'd255, 8'd255, 8'd255);
    row_item(8'd0, 8'd255, 8'd0);
    row_item(8'd0, 8'd0, 8'd255);
    // A zero window flags every result and leaves the state alone.
    row_reg(owa_pkg::CfgWindowLen, 8'd0);
    row_pin(8'd17, 8'd3, 8'd9, 29'd0, 1'b1);
    row_pin(8'd255, 8'd255, 8'd255, 29'd0, 1'b1);
    // Largest key with a one-entry window gives the largest mean; the window
    // is shortened from five entries to one on the way.
    row_reg(owa_pkg::CfgKeyCode, 8'd255);
    row_reg(owa_pkg::CfgWindowLen, 8'd1);
    row_pin(8'd255, 8'd255, 8'd255, 29'd473033160, 1'b0);
    row_pin(8'd0, 8'd0, 8'd0, 29'd0, 1'b0);
    // Smallest nonzero key, longest window.
    row_reg(owa_pkg::CfgKeyCode, 8'd1);
    row_reg(owa_pkg::CfgWindowLen, 8'd128);
    row_item(8'd20, 8'd9, 8'd0);
    row_item(8'd255, 8'd0, 8'd255);
    row_item(8'd128, 8'd64, 8'd32);
    row_item(8'd1, 8'd2, 8'd3);
    row_item(8'd85, 8'd170, 8'd85);
    row_item(8'd254, 8'd127, 8'd1);
    // Shortened window: the sum is rebuilt from the newest three entries.
    row_reg(owa_pkg::CfgWindowLen, 8'd3);
    row_item(8'd21, 8'd0, 8'd0);
    row_item(8'd19, 8'd5, 8'd7);
    // Lengths past the ring size act as the ring size.
    row_reg(owa_pkg::CfgWindowLen, 8'd200);
    row_item(8'd255, 8'd255, 8'd0);
    row_item(8'd3, 8'd255, 8'd255);
    row_reg(owa_pkg::CfgWindowLen, 8'd255);
    row_item(8'd170, 8'd85, 8'd170);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan_q[i]) begin
      row = plan_q[i];
      if (row.kind == RowReg) write_reg(row.reg_idx, row.w);
      else send_reading(row.w, row.t, row.h, row.pinned, row.mean, row.dis);
    end
    n = readings_sent;

    // Random phases, each under its own key and window length.
    for (ph = 0; ph < 10; ph++) begin
      key = pick_byte();
      count = 40;
      case (ph)
        0: begin key = 8'd0; len = 8'd10; end
        1: begin key = 8'd255; len = 8'd128; end
        2: begin key = 8'd1; len = 8'd1; count = 30; end
        3: len = 8'($urandom_range(2, 16));
        4: begin len = 8'd0; count = 12; end
        5: len = 8'd128;
        6: begin len = 8'd4; count = 30; end
        // Long enough to fill the whole ring and slide past it.
        7: begin len = 8'd255; count = 140; end
        8: len = 8'($urandom_range(1, 128));
        default: len = 8'($urandom_range(0, 255));
      endcase
      write_reg(owa_pkg::CfgKeyCode, key);
      write_reg(owa_pkg::CfgWindowLen, len);
      settings_seen++;
      steady = (ph == 3);
      repeat (count) begin
        send_reading(pick_byte(), pick_byte(), pick_byte(), 1'b0, '0, 1'b0);
        if ($urandom_range(0, 99) == 0) settle();
      end
      steady = 1'b0;
    end

    settle();
    repeat (60) @(posedge clk_i);
    $display("Sent %0d readings (%0d from the directed table) under %0d random settings.",
             readings_sent, n, settings_seen);
    $display("Checked %0d means, %0d mismatches.", means_checked, err_cnt);
    if (err_cnt == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Timed out with %0d results outstanding.", pending_means.size());
    $display("status: fail");
    $finish;
  end

endmodule

[files.f]
sv/owa_pkg.sv
sv/owa_ring_mem.sv
sv/owa_scaler.sv
sv/owa_divider.sv
sv/oxygen_window_averager_core.sv
sv/owa_checker.sv
bench/tb_top.sv
